### rtl/core/daq_ewd_pkg.sv
// shared types and constants of the event word deframer
// no dependencies; used by every module in rtl/core but daq_ewd_fifo
package daq_ewd_pkg;

   // defaults for top-level parameters
   localparam int MAX_SAMPLES_DEF = 4096;
   localparam int QUEUE_DEPTH_DEF = 2;

   // fixed framing constants
   localparam int TIME_WORDS   = 4;
   localparam int HEADER_WORDS = 2;

   // field widths
   localparam int WORD_W   = 16;
   localparam int VALUE_W  = 14;
   localparam int FLAG_W   = 2;
   localparam int POS_W    = 17;
   localparam int CHAN_W   = 15;
   localparam int EVNUM_W  = 32;
   localparam int TIME_W   = 64;
   localparam int INDEX_W  = 12;
   localparam int PAYLD_W  = 16;
   localparam int SCOUNT_W = 13;
   localparam int OFFS_W   = 14;
   localparam int TCNT_W   = 2;

   // flag codes carried in bits 1:0 of a data word
   localparam logic [FLAG_W-1:0] FLAG_START = 2'd1;
   localparam logic [FLAG_W-1:0] FLAG_PULSE = 2'd3;

   // record kinds
   localparam logic RECORD_HEADER = 1'b0;
   localparam logic RECORD_SAMPLE = 1'b1;

   // configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAYLOAD_WORDS  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_COUNT   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_OFFSET = 2'd2;

   // configuration reset values
   localparam logic [PAYLD_W-1:0]  PAYLOAD_WORDS_RST  = 16'd512;
   localparam logic [SCOUNT_W-1:0] SAMPLE_COUNT_RST   = 13'd1024;
   localparam logic [OFFS_W-1:0]   CHANNEL_OFFSET_RST = 14'd0;

   // one output record
   typedef struct packed {
      logic                record_kind;
      logic [CHAN_W-1:0]   channel;
      logic                start_ok;
      logic [EVNUM_W-1:0]  event_number;
      logic [TIME_W-1:0]   raw_time;
      logic [VALUE_W-1:0]  sample_value;
      logic [INDEX_W-1:0]  sample_index;
      logic                last;
      logic                test_pulse;
   } record_type;

   localparam int RECORD_W = $bits(record_type);

endpackage

### rtl/core/daq_ewd_fifo.sv
// small register queue with count, used between front and back and on the output
// depends on nothing but its parameters
module daq_ewd_fifo #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty,
   output logic             full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CNT_FULL);
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   // occupancy never passes the depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("queue count above depth");

   // a lone push grows the count by one
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not grow on push");

   // pointers meet exactly when empty or full
   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff == rd_ptr_ff) == (empty || full))
      else $error("queue pointers disagree with count");

endmodule

### rtl/core/daq_ewd_front.sv
// front part: accepts raw words, tracks the array period and drops header words
// depends on daq_ewd_pkg
module daq_ewd_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   input  logic [daq_ewd_pkg::WORD_W-1:0]  req_data_word,
   output logic                            req_full,
   input  logic [daq_ewd_pkg::PAYLD_W-1:0] payload_words,
   input  logic                            queue_full,
   output logic                            word_push,
   output logic [daq_ewd_pkg::WORD_W-1:0]  word_data
);

   localparam int SUM_W = daq_ewd_pkg::POS_W + 1;

   logic [daq_ewd_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [SUM_W-1:0]              period;
   logic [SUM_W-1:0]              pos_plus;
   logic                          accept;
   logic                          is_header;

   assign req_full  = queue_full;
   assign accept    = req_push & ~queue_full;
   assign is_header = (pos_ff < daq_ewd_pkg::POS_W'(daq_ewd_pkg::HEADER_WORDS));
   assign word_push = accept & ~is_header;
   assign word_data = req_data_word;

   // position within the array period, wraps after the last payload word
   always_comb begin
      period   = SUM_W'(payload_words) + SUM_W'(daq_ewd_pkg::HEADER_WORDS);
      pos_plus = SUM_W'(pos_ff) + 1'b1;
      pos_in   = pos_ff;
      if (accept) begin
         pos_in = (pos_plus >= period) ? '0 : pos_plus[daq_ewd_pkg::POS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

### rtl/core/daq_ewd_back.sv
// back part: decodes channel, timestamp and sample words into records
// depends on daq_ewd_pkg
module daq_ewd_back #(
   parameter int MAX_SAMPLES = daq_ewd_pkg::MAX_SAMPLES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             word_valid,
   input  logic [daq_ewd_pkg::WORD_W-1:0]   word_data,
   output logic                             word_pop,
   input  logic [daq_ewd_pkg::SCOUNT_W-1:0] sample_count,
   input  logic [daq_ewd_pkg::OFFS_W-1:0]   ch_offset,
   input  logic                             rec_full,
   output logic                             rec_push,
   output daq_ewd_pkg::record_type          rec
);

   localparam int CNT_W  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int MAXN_W = $clog2(MAX_SAMPLES + 1);
   localparam int N_W    = ((MAXN_W > daq_ewd_pkg::SCOUNT_W) ? MAXN_W
                                                            : daq_ewd_pkg::SCOUNT_W) + 1;
   localparam logic [N_W-1:0] MAX_N = N_W'(MAX_SAMPLES);
   localparam logic [daq_ewd_pkg::TCNT_W-1:0] TCNT_LAST =
      daq_ewd_pkg::TCNT_W'(daq_ewd_pkg::TIME_WORDS - 1);

   typedef enum logic [2:0] {
      PH_CHANNEL = 3'b001,
      PH_TIME    = 3'b010,
      PH_SAMPLES = 3'b100
   } phase_type;

   phase_type                          phase_ff, phase_in;
   logic [CNT_W-1:0]                   cnt_ff, cnt_in;
   logic [daq_ewd_pkg::TCNT_W-1:0]     tcnt_ff, tcnt_in;
   logic [daq_ewd_pkg::TIME_W-1:0]     time_ff, time_in;
   logic [daq_ewd_pkg::CHAN_W-1:0]     chan_ff, chan_in;
   logic                               start_ok_ff, start_ok_in;
   logic                               pulse_ff, pulse_in;
   logic [daq_ewd_pkg::EVNUM_W-1:0]    evnum_ff, evnum_in;

   logic [daq_ewd_pkg::VALUE_W-1:0]    value;
   logic [daq_ewd_pkg::FLAG_W-1:0]     flag;
   logic [N_W-1:0]                     nsamp;
   logic [N_W-1:0]                     cnt_plus;
   logic                               is_last;

   assign value    = word_data[daq_ewd_pkg::WORD_W-1:daq_ewd_pkg::FLAG_W];
   assign flag     = word_data[daq_ewd_pkg::FLAG_W-1:0];
   assign word_pop = word_valid & ~rec_full;

   // effective sample count, clamped to one and to the maximum
   always_comb begin
      nsamp = N_W'(sample_count);
      if (nsamp == '0) begin
         nsamp = N_W'(1);
      end else if (nsamp > MAX_N) begin
         nsamp = MAX_N;
      end
   end

   assign cnt_plus = N_W'(cnt_ff) + 1'b1;
   assign is_last  = (cnt_plus >= nsamp);

   // event decode
   always_comb begin
      phase_in    = phase_ff;
      cnt_in      = cnt_ff;
      tcnt_in     = tcnt_ff;
      time_in     = time_ff;
      chan_in     = chan_ff;
      start_ok_in = start_ok_ff;
      pulse_in    = pulse_ff;
      evnum_in    = evnum_ff;
      rec_push    = 1'b0;
      rec         = '0;
      if (word_pop) begin
         case (phase_ff)
            PH_TIME: begin
               time_in = {time_ff[daq_ewd_pkg::TIME_W-daq_ewd_pkg::WORD_W-1:0], word_data};
               tcnt_in = tcnt_ff + 1'b1;
               if (tcnt_ff == TCNT_LAST) begin
                  evnum_in         = evnum_ff + 1'b1;
                  rec_push         = 1'b1;
                  rec.record_kind  = daq_ewd_pkg::RECORD_HEADER;
                  rec.channel      = chan_ff;
                  rec.start_ok     = start_ok_ff;
                  rec.event_number = evnum_in;
                  rec.raw_time     = time_in;
                  phase_in         = PH_SAMPLES;
                  cnt_in           = '0;
                  tcnt_in          = '0;
                  pulse_in         = 1'b0;
               end
            end
            PH_SAMPLES: begin
               pulse_in         = pulse_ff | (flag == daq_ewd_pkg::FLAG_PULSE);
               rec_push         = 1'b1;
               rec.record_kind  = daq_ewd_pkg::RECORD_SAMPLE;
               rec.sample_value = value;
               rec.sample_index = daq_ewd_pkg::INDEX_W'(cnt_ff);
               rec.last         = is_last;
               rec.test_pulse   = is_last & pulse_in;
               if (is_last) begin
                  phase_in = PH_CHANNEL;
                  cnt_in   = '0;
               end else begin
                  cnt_in = cnt_plus[CNT_W-1:0];
               end
            end
            default: begin
               // channel word, also taken for any unexpected phase code
               chan_in     = daq_ewd_pkg::CHAN_W'(value)
                           - daq_ewd_pkg::CHAN_W'(ch_offset);
               start_ok_in = (flag == daq_ewd_pkg::FLAG_START);
               time_in     = '0;
               cnt_in      = '0;
               tcnt_in     = '0;
               phase_in    = PH_TIME;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_CHANNEL;
         cnt_ff      <= '0;
         tcnt_ff     <= '0;
         time_ff     <= '0;
         chan_ff     <= '0;
         start_ok_ff <= 1'b0;
         pulse_ff    <= 1'b0;
         evnum_ff    <= '0;
      end else begin
         phase_ff    <= phase_in;
         cnt_ff      <= cnt_in;
         tcnt_ff     <= tcnt_in;
         time_ff     <= time_in;
         chan_ff     <= chan_in;
         start_ok_ff <= start_ok_in;
         pulse_ff    <= pulse_in;
         evnum_ff    <= evnum_in;
      end
   end

   // a record leaves only with a word taken from the queue
   a_push_needs_word: assert property (@(posedge clock) disable iff (reset)
      rec_push |-> word_pop)
      else $error("record produced without a word");

   // every sample word gives a record
   a_sample_records: assert property (@(posedge clock) disable iff (reset)
      (word_pop && phase_ff == PH_SAMPLES) |-> rec_push)
      else $error("sample word produced no record");

   // a header record bumps the event number by one
   a_event_count: assert property (@(posedge clock) disable iff (reset)
      (rec_push && rec.record_kind == daq_ewd_pkg::RECORD_HEADER)
         |=> (evnum_ff == $past(evnum_ff) + 1'b1))
      else $error("event number not advanced on header record");

endmodule

### rtl/core/daq_event_word_deframer_top.sv
// Event word deframer, top level.
//
// Use: raw 16-bit digitizer words enter on the request channel (req_push /
// req_full, req_data_word); a word is taken at a clock edge with req_push
// high and req_full low. Records leave on the response channel: while
// rsp_empty is low the oldest record sits on the rsp_ ports and is taken at
// an edge with rsp_pop high. Configuration is written through csr_valid /
// csr_ready with csr_index and csr_wdata; csr_ready is always high, and
// writes should be made while no words are in flight.
// Throughput: one word per cycle while req_full is low. The front strips
// array headers, a short queue holds data words, the back decodes them and
// writes a record queue. A record reaches the rsp_ ports once its last word
// has passed the word queue and the back has written it to the record queue.
// When the receiver stalls, the record queue fills, then the
// word queue, and req_full rises; no word or record is lost.
// Reset (synchronous, active high) empties both queues, sets the array
// position and event state to the start and restores register defaults.
// depends on daq_ewd_pkg, daq_ewd_front, daq_ewd_fifo, daq_ewd_back
module daq_event_word_deframer_top #(
   parameter int MAX_SAMPLES = daq_ewd_pkg::MAX_SAMPLES_DEF,
   parameter int QUEUE_DEPTH = daq_ewd_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_push,
   output logic                                  req_full,
   input  logic [daq_ewd_pkg::WORD_W-1:0]        req_data_word,
   // response channel
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output logic                                  rsp_record_kind,
   output logic signed [daq_ewd_pkg::CHAN_W-1:0] rsp_channel,
   output logic                                  rsp_start_ok,
   output logic [daq_ewd_pkg::EVNUM_W-1:0]       rsp_event_number,
   output logic [daq_ewd_pkg::TIME_W-1:0]        rsp_raw_time,
   output logic [daq_ewd_pkg::VALUE_W-1:0]       rsp_sample_value,
   output logic [daq_ewd_pkg::INDEX_W-1:0]       rsp_sample_index,
   output logic                                  rsp_last,
   output logic                                  rsp_test_pulse,
   // configuration port
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [daq_ewd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [daq_ewd_pkg::PAYLD_W-1:0]       csr_wdata
);

   logic [daq_ewd_pkg::PAYLD_W-1:0]  payload_words_ff;
   logic [daq_ewd_pkg::SCOUNT_W-1:0] sample_count_ff;
   logic [daq_ewd_pkg::OFFS_W-1:0]   ch_offset_ff;

   logic                             word_push;
   logic [daq_ewd_pkg::WORD_W-1:0]   word_data;
   logic                             word_full;
   logic                             word_empty;
   logic [daq_ewd_pkg::WORD_W-1:0]   word_head;
   logic                             word_pop;

   logic                             rec_push;
   logic                             rec_full;
   daq_ewd_pkg::record_type          rec_in;
   daq_ewd_pkg::record_type          rec_head;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         payload_words_ff <= daq_ewd_pkg::PAYLOAD_WORDS_RST;
         sample_count_ff  <= daq_ewd_pkg::SAMPLE_COUNT_RST;
         ch_offset_ff     <= daq_ewd_pkg::CHANNEL_OFFSET_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            daq_ewd_pkg::CSR_PAYLOAD_WORDS: begin
               payload_words_ff <= csr_wdata;
            end
            daq_ewd_pkg::CSR_SAMPLE_COUNT: begin
               sample_count_ff <= csr_wdata[daq_ewd_pkg::SCOUNT_W-1:0];
            end
            daq_ewd_pkg::CSR_CHANNEL_OFFSET: begin
               ch_offset_ff <= csr_wdata[daq_ewd_pkg::OFFS_W-1:0];
            end
            default: begin
               // unknown index, write ignored
            end
         endcase
      end
   end

   // header stripping
   daq_ewd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_data_word (req_data_word),
      .req_full      (req_full),
      .payload_words (payload_words_ff),
      .queue_full    (word_full),
      .word_push     (word_push),
      .word_data     (word_data)
   );

   // data word queue
   daq_ewd_fifo #(
      .WIDTH (daq_ewd_pkg::WORD_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_word_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (word_push),
      .push_data (word_data),
      .pop       (word_pop),
      .pop_data  (word_head),
      .empty     (word_empty),
      .full      (word_full)
   );

   // event decode
   daq_ewd_back #(
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .word_valid   (~word_empty),
      .word_data    (word_head),
      .word_pop     (word_pop),
      .sample_count (sample_count_ff),
      .ch_offset    (ch_offset_ff),
      .rec_full     (rec_full),
      .rec_push     (rec_push),
      .rec          (rec_in)
   );

   // record queue
   daq_ewd_fifo #(
      .WIDTH (daq_ewd_pkg::RECORD_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_rec_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rec_push),
      .push_data (rec_in),
      .pop       (rsp_pop),
      .pop_data  (rec_head),
      .empty     (rsp_empty),
      .full      (rec_full)
   );

   // response fields
   assign rsp_record_kind  = rec_head.record_kind;
   assign rsp_channel      = rec_head.channel;
   assign rsp_start_ok     = rec_head.start_ok;
   assign rsp_event_number = rec_head.event_number;
   assign rsp_raw_time     = rec_head.raw_time;
   assign rsp_sample_value = rec_head.sample_value;
   assign rsp_sample_index = rec_head.sample_index;
   assign rsp_last         = rec_head.last;
   assign rsp_test_pulse   = rec_head.test_pulse;

endmodule
